>>> design/mch_pkg.sv
// ----------------------------------------------------------------------------
// mch_pkg: shared types and constants for the compass heading pipeline
// Fixed-point formats, CORDIC arctangent table and the data word that moves
// from cell to cell.
// ----------------------------------------------------------------------------
package mch_pkg;

    localparam int ANGLE_FRAC_BITS = 7;
    localparam int CORDIC_STAGES   = 16;

    localparam int IN_W       = 16;
    localparam int OUT_W      = 16;
    localparam int ACC_FRAC   = 24;
    localparam int PRE_SHIFT  = 14;
    localparam int TABLE_LEN  = 24;
    localparam int NUM_STAGES = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
    localparam int IDX_W      = 5;

    // vector components: |u|,|v| < 2^31 after CORDIC gain
    localparam int XY_W  = 34;
    // angle accumulator in degrees, ACC_FRAC fraction bits
    localparam int ACC_W = 36;

    localparam int RND_SH = ACC_FRAC - ANGLE_FRAC_BITS;

    localparam logic signed [ACC_W-1:0] DEG_90  = ACC_W'(64'sd90  <<< ACC_FRAC);
    localparam logic signed [ACC_W-1:0] DEG_180 = ACC_W'(64'sd180 <<< ACC_FRAC);
    localparam logic signed [ACC_W-1:0] DEG_360 = ACC_W'(64'sd360 <<< ACC_FRAC);
    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(64'sd1 <<< (RND_SH - 1));
    localparam logic [ACC_W-1:0] FULL_TURN = ACC_W'(64'd360 << ANGLE_FRAC_BITS);

    typedef struct packed {
        logic signed [XY_W-1:0]  u;
        logic signed [XY_W-1:0]  v;
        logic signed [ACC_W-1:0] z;
        logic                    zero;
    } t_cordic;

    // atan(2^-i) in degrees, ACC_FRAC fraction bits
    function automatic logic signed [ACC_W-1:0] atan_deg(input logic [IDX_W-1:0] idx);
        logic signed [ACC_W-1:0] r;
        begin
            case (idx)
                5'd0:    r = 36'sd754974720;
                5'd1:    r = 36'sd445687602;
                5'd2:    r = 36'sd235489088;
                5'd3:    r = 36'sd119537938;
                5'd4:    r = 36'sd60000934;
                5'd5:    r = 36'sd30029717;
                5'd6:    r = 36'sd15018523;
                5'd7:    r = 36'sd7509720;
                5'd8:    r = 36'sd3754917;
                5'd9:    r = 36'sd1877466;
                5'd10:   r = 36'sd938734;
                5'd11:   r = 36'sd469367;
                5'd12:   r = 36'sd234684;
                5'd13:   r = 36'sd117342;
                5'd14:   r = 36'sd58671;
                5'd15:   r = 36'sd29335;
                5'd16:   r = 36'sd14668;
                5'd17:   r = 36'sd7334;
                5'd18:   r = 36'sd3667;
                5'd19:   r = 36'sd1833;
                5'd20:   r = 36'sd917;
                5'd21:   r = 36'sd458;
                5'd22:   r = 36'sd229;
                5'd23:   r = 36'sd115;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

>>> design/mch_prep.sv
// ----------------------------------------------------------------------------
// mch_prep: input stage of the heading pipeline
// Forms the vector (x, -y), folds it into the right half plane and scales it
// into the CORDIC format.
// ----------------------------------------------------------------------------
module mch_prep
    import mch_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic signed [IN_W-1:0] i_mag_x,
    input  logic signed [IN_W-1:0] i_mag_y,
    output logic                   o_valid,
    input  logic                   i_ready,
    output t_cordic                o_data
);

    logic                    r_valid;
    t_cordic                 r_data;
    t_cordic                 n_data;
    logic signed [IN_W:0]    x_e;
    logic signed [IN_W:0]    v_e;
    logic signed [IN_W:0]    u_f;
    logic signed [IN_W:0]    v_f;
    logic                    flip;

    always_comb begin
        x_e  = {i_mag_x[IN_W-1], i_mag_x};
        v_e  = -{i_mag_y[IN_W-1], i_mag_y};
        flip = i_mag_x[IN_W-1];
        u_f  = flip ? -x_e : x_e;
        v_f  = flip ? -v_e : v_e;
        n_data.u    = {{(XY_W-IN_W-1){u_f[IN_W]}}, u_f} <<< PRE_SHIFT;
        n_data.v    = {{(XY_W-IN_W-1){v_f[IN_W]}}, v_f} <<< PRE_SHIFT;
        n_data.z    = flip ? DEG_180 : '0;
        n_data.zero = (i_mag_x == '0) && (i_mag_y == '0);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> design/mch_cell.sv
// ----------------------------------------------------------------------------
// mch_cell: one vectoring CORDIC micro-rotation
// Rotates toward the x axis by atan(2^-idx) and registers the result with its
// own valid bit; stalls only when full and the next cell cannot take data.
// ----------------------------------------------------------------------------
module mch_cell
    import mch_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_idx,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_cordic          i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output t_cordic          o_data
);

    logic                    r_valid;
    t_cordic                 r_data;
    t_cordic                 n_data;
    logic signed [XY_W-1:0]  du;
    logic signed [XY_W-1:0]  dv;
    logic signed [ACC_W-1:0] ang;

    always_comb begin
        du  = i_data.v >>> i_idx;
        dv  = i_data.u >>> i_idx;
        ang = atan_deg(i_idx);
        n_data.zero = i_data.zero;
        // zero residual rotates as positive
        if (!i_data.v[XY_W-1]) begin
            n_data.u = i_data.u + du;
            n_data.v = i_data.v - dv;
            n_data.z = i_data.z + ang;
        end else begin
            n_data.u = i_data.u - du;
            n_data.v = i_data.v + dv;
            n_data.z = i_data.z - ang;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> design/mch_post.sv
// ----------------------------------------------------------------------------
// mch_post: heading conversion and output register
// Subtracts 90 degrees, folds into [0, 360), rounds to the output LSB and
// holds the result until it is transferred.
// ----------------------------------------------------------------------------
module mch_post
    import mch_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_cordic          i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [OUT_W-1:0] o_heading
);

    logic                    r_valid;
    logic [OUT_W-1:0]        r_heading;
    logic [OUT_W-1:0]        n_heading;
    logic signed [ACC_W-1:0] z;
    logic signed [ACC_W-1:0] h0;
    logic signed [ACC_W-1:0] h1;
    logic [ACC_W-1:0]        q0;
    logic [ACC_W-1:0]        q1;

    always_comb begin
        z  = i_data.zero ? '0 : i_data.z;
        h0 = z - DEG_90;
        h1 = h0[ACC_W-1] ? h0 + DEG_360 : h0;
        if (h1 >= DEG_360) begin
            h1 = h1 - DEG_360;
        end
        if (h1[ACC_W-1]) begin
            h1 = '0;
        end
        q0 = ACC_W'(unsigned'(h1 + RND_HALF) >> RND_SH);
        // rounds up to a full turn: wrap to zero
        q1 = (q0 >= FULL_TURN) ? q0 - FULL_TURN : q0;
        n_heading = q1[OUT_W-1:0];
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_heading <= n_heading;
        end
    end

    assign o_valid   = r_valid;
    assign o_heading = r_heading;

endmodule

>>> design/magnetometer_compass_heading.sv
// ----------------------------------------------------------------------------
// magnetometer_compass_heading: compass heading from a magnetometer sample
// Pipelined vectoring CORDIC computing atan2(-y, x) - 90 degrees in [0, 360).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_ready carries i_mag_x, i_mag_y (signed 16 bit).
//   Output channel o_valid/i_ready carries o_heading, unsigned, in units of
//   1/128 degree (0..46079); both inputs zero give 270 degrees.
//   One result per input, in order. A transfer happens on a clock edge with
//   valid and ready both high.
// Stages: the input stage loads on the transfer edge, then NUM_STAGES cells
//   (one per micro-rotation, 16 micro-rotations) and one output stage follow.
// Throughput: one sample per clock while i_ready is high; each cell is a
//   register stage with its own valid bit.
// Stall: each stage holds while full and its successor is full and stalled,
//   so bubbles are squeezed out and new samples are still taken while a
//   result waits at the output. o_ready drops only when every stage is full.
// Reset: i_rst_n (synchronous, active low) empties the pipeline.
// ----------------------------------------------------------------------------
module magnetometer_compass_heading
    import mch_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic signed [IN_W-1:0] i_mag_x,
    input  logic signed [IN_W-1:0] i_mag_y,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [OUT_W-1:0]       o_heading
);

    t_cordic chain_data  [NUM_STAGES+1];
    logic    chain_valid [NUM_STAGES+1];
    logic    chain_ready [NUM_STAGES+1];

    mch_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_mag_x (i_mag_x),
        .i_mag_y (i_mag_y),
        .o_valid (chain_valid[0]),
        .i_ready (chain_ready[0]),
        .o_data  (chain_data[0])
    );

    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_cell
        mch_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(k)),
            .i_valid (chain_valid[k]),
            .o_ready (chain_ready[k]),
            .i_data  (chain_data[k]),
            .o_valid (chain_valid[k+1]),
            .i_ready (chain_ready[k+1]),
            .o_data  (chain_data[k+1])
        );
    end

    mch_post u_post (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (chain_valid[NUM_STAGES]),
        .o_ready   (chain_ready[NUM_STAGES]),
        .i_data    (chain_data[NUM_STAGES]),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_heading (o_heading)
    );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for magnetometer_compass_heading
// Drives (x, y) sample pairs through the valid/ready input channel, predicts
// each heading with a bit-level CORDIC model of its own and checks the output
// stream in order, allowing the 1 LSB that the design is permitted to differ.
// ----------------------------------------------------------------------------
module testbench;
    import mch_pkg::*;

    localparam int  CLK_HALF      = 5;
    localparam int  RST_CYCLES    = 7;
    localparam int  PIPE_LATENCY  = NUM_STAGES + 2;
    localparam int  RX_HOLD_LEN   = 300;
    localparam int  WDOG_LIMIT    = 4000;
    localparam int  ANG_FRAC      = 24;
    localparam int  VEC_SHIFT     = 14;
    localparam int  ATAN_ENTRIES  = 24;
    localparam longint TURN_LSB   = longint'(360) << ANGLE_FRAC_BITS;

    typedef struct {
        logic signed [IN_W-1:0] x;
        logic signed [IN_W-1:0] y;
        logic [OUT_W-1:0]       heading;
    } t_heading_exp;

    logic                   i_clk     = 1'b0;
    logic                   i_rst_n   = 1'b0;
    logic                   i_valid   = 1'b0;
    logic signed [IN_W-1:0] i_mag_x   = '0;
    logic signed [IN_W-1:0] i_mag_y   = '0;
    logic                   i_ready   = 1'b0;
    logic                   o_ready;
    logic                   o_valid;
    logic [OUT_W-1:0]       o_heading;

    t_heading_exp heading_q[$];
    int  n_fail    = 0;
    int  n_sent    = 0;
    int  n_checked = 0;
    int  wdog_cnt  = 0;
    bit  rx_stalls = 1'b0;
    bit  rx_hold_req = 1'b0;
    int  rx_hold_left = 0;
    int  rx_busy_left = 0;

    // atan(2^-i) in degrees, 24 fraction bits
    longint atan_lut [ATAN_ENTRIES] = '{
        754974720, 445687602, 235489088, 119537938,
        60000934,  30029717,  15018523,  7509720,
        3754917,   1877466,   938734,    469367,
        234684,    117342,    58671,     29335,
        14668,     7334,      3667,      1833,
        917,       458,       229,       115
    };

    magnetometer_compass_heading u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_mag_x   (i_mag_x),
        .i_mag_y   (i_mag_y),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_heading (o_heading)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // heading predictor
    // ------------------------------------------------------------------
    function automatic logic [OUT_W-1:0] predict_heading(input logic signed [IN_W-1:0] mx,
                                                          input logic signed [IN_W-1:0] my);
        longint u, v, z, du, dv, h, q;
        int     rsh;
        begin
            u   = mx;
            v   = -longint'(my);
            z   = 0;
            rsh = ANG_FRAC - ANGLE_FRAC_BITS;
            if (u != 0 || v != 0) begin
                // left half-plane: flip the vector, start from 180 degrees
                if (u < 0) begin
                    u = -u;
                    v = -v;
                    z = longint'(180) <<< ANG_FRAC;
                end
                u = u <<< VEC_SHIFT;
                v = v <<< VEC_SHIFT;
                for (int i = 0; i < CORDIC_STAGES && i < ATAN_ENTRIES; i++) begin
                    du = v >>> i;
                    dv = u >>> i;
                    if (v >= 0) begin
                        u = u + du;
                        v = v - dv;
                        z = z + atan_lut[i];
                    end else begin
                        u = u - du;
                        v = v + dv;
                        z = z - atan_lut[i];
                    end
                end
            end
            h = z - (longint'(90) <<< ANG_FRAC);
            if (h < 0)
                h = h + (longint'(360) <<< ANG_FRAC);
            if (h >= (longint'(360) <<< ANG_FRAC))
                h = h - (longint'(360) <<< ANG_FRAC);
            if (h < 0)
                h = 0;
            q = (h + (longint'(1) <<< (rsh - 1))) >>> rsh;
            if (q >= TURN_LSB)
                q = q - TURN_LSB;
            return q[OUT_W-1:0];
        end
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                return 0;
            if (r < 85)
                return $urandom_range(1, 3);
            if (r < 97)
                return $urandom_range(4, 12);
            return $urandom_range(20, 60);
        end
    endfunction

    function automatic logic signed [IN_W-1:0] rand_axis();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                return IN_W'($urandom);
            if (r < 75)
                return IN_W'(int'($urandom_range(0, 128)) - 64);
            if (r < 88)
                return IN_W'(int'($urandom_range(0, 4096)) - 2048);
            case ($urandom_range(0, 4))
                0:       return 16'sh8000;
                1:       return 16'sh7FFF;
                2:       return 16'sh0000;
                3:       return 16'sh0001;
                default: return 16'shFFFF;
            endcase
        end
    endfunction

    // ------------------------------------------------------------------
    // sender: one transfer, then an optional gap with valid low
    // ------------------------------------------------------------------
    task automatic send_sample(input logic signed [IN_W-1:0] mx,
                               input logic signed [IN_W-1:0] my,
                               input int gap);
        t_heading_exp e;
        begin
            e.x       = mx;
            e.y       = my;
            e.heading = predict_heading(mx, my);
            i_valid  <= 1'b1;
            i_mag_x  <= mx;
            i_mag_y  <= my;
            do
                @(posedge i_clk);
            while (!o_ready);
            heading_q.push_back(e);
            n_sent++;
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_drained();
        begin
            while (heading_q.size() != 0)
                @(posedge i_clk);
        end
    endtask

    task automatic send_random_pair(input int gap);
        logic signed [IN_W-1:0] mx, my;
        begin
            mx = rand_axis();
            my = rand_axis();
            case ($urandom_range(0, 9))
                0:       my = '0;
                1:       mx = '0;
                2:       my = mx;
                3:       my = -mx;
                default: ;
            endcase
            send_sample(mx, my, gap);
        end
    endtask

    // ------------------------------------------------------------------
    // receiver: ready with random stalls, plus a long hold on request
    // ------------------------------------------------------------------
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_left = RX_HOLD_LEN;
                rx_hold_req  = 1'b0;
            end
            if (rx_hold_left > 0) begin
                i_ready <= 1'b0;
                rx_hold_left--;
            end else if (rx_busy_left > 0) begin
                i_ready <= 1'b0;
                rx_busy_left--;
            end else begin
                i_ready <= 1'b1;
                if (rx_stalls && $urandom_range(0, 3) == 0)
                    rx_busy_left = idle_len();
            end
        end
    end

    // ------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_heading_exp e;
        longint       d;
        if (i_rst_n && o_valid && i_ready) begin
            if (heading_q.size() == 0) begin
                $error("heading: unexpected result, actual %0d", o_heading);
                n_fail++;
            end else begin
                e = heading_q.pop_front();
                n_checked++;
                // design is allowed 1 LSB off, modulo a full turn
                d = (longint'(o_heading) - longint'(e.heading) + TURN_LSB) % TURN_LSB;
                if (longint'(o_heading) >= TURN_LSB || !(d == 0 || d == 1 || d == TURN_LSB - 1))
                begin
                    $error("heading: x=%0d y=%0d expected %0d actual %0d",
                           e.x, e.y, e.heading, o_heading);
                    n_fail++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready))
                wdog_cnt <= 0;
            else
                wdog_cnt <= wdog_cnt + 1;
            if (wdog_cnt >= WDOG_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", WDOG_LIMIT);
                $display("testbench failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        begin
            rx_stalls = 1'b0;
            send_sample(16'sd0,      16'sd0,      0); // no direction: 270 deg
            send_sample(16'sd32767,  16'sd0,      0); // zero residual at stage 0
            send_sample(-16'sd32768, 16'sd0,      0); // exactly 180 deg
            send_sample(16'sd0,      16'sd32767,  0);
            send_sample(16'sd0,      -16'sd32768, 0);
            send_sample(-16'sd32768, -16'sd32768, 0);
            send_sample(16'sd32767,  16'sd32767,  0);
            send_sample(-16'sd32768, 16'sd32767,  0);
            send_sample(16'sd32767,  -16'sd32768, 0);
            send_sample(16'sd1,      16'sd0,      0);
            send_sample(-16'sd1,     16'sd0,      0);
            send_sample(16'sd0,      16'sd1,      0);
            send_sample(16'sd0,      -16'sd1,     0);
            send_sample(16'sd1,      16'sd1,      0);
            send_sample(-16'sd1,     -16'sd1,     0);
            send_sample(-16'sd1,     16'sd1,      0);
            // just below 90 deg of atan2: heading rounds to 360 and wraps
            send_sample(16'sd1,      -16'sd32768, 0);
            send_sample(16'sd1,      -16'sd32767, 0);
            send_sample(-16'sd1,     -16'sd32768, 0);
            send_sample(16'sd1,      16'sd32767,  0);
            send_sample(16'sd100,    16'sd0,      0);
            send_sample(-16'sd100,   16'sd1,      1);
            wait_drained();
        end
    endtask

    task automatic test_random_stream(input int count);
        begin
            rx_stalls = 1'b1;
            for (int i = 0; i < count; i++)
                send_random_pair((i == count - 1) ? 1 : idle_len());
        end
    endtask

    task automatic test_back_to_back(input int count);
        begin
            rx_stalls = 1'b0;
            for (int i = 0; i < count; i++)
                send_random_pair((i == count - 1) ? 1 : 0);
        end
    endtask

    // receiver holds off long enough for the pipeline to fill and stall input
    task automatic test_output_hold(input int count);
        begin
            rx_stalls   = 1'b0;
            rx_hold_req = 1'b1;
            for (int i = 0; i < count; i++)
                send_random_pair((i == count - 1) ? 1 : 0);
        end
    endtask

    // bursts separated by a full drain of the pipeline
    task automatic test_drain_pause(input int bursts, input int count);
        begin
            rx_stalls = 1'b1;
            for (int b = 0; b < bursts; b++) begin
                for (int i = 0; i < count; i++)
                    send_random_pair((i == count - 1) ? 1 : idle_len());
                wait_drained();
            end
        end
    endtask

    initial begin
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_stream(1200);
        test_back_to_back(300);
        test_output_hold(150);
        test_drain_pause(3, 40);

        wait_drained();
        repeat (PIPE_LATENCY + 10) @(posedge i_clk);

        $display("covered %0d samples, %0d headings checked: axis extremes, zero vector,",
                 n_sent, n_checked);
        $display("wrap at 360, random gaps, back-to-back, %0d-cycle output hold, drain pauses",
                 RX_HOLD_LEN);
        if (n_fail == 0 && heading_q.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
